>>> sv/tsdp_pkg.sv
`timescale 1ns / 1ps
// shared types and character codes for the two-field signed decimal parser
package tsdp_pkg;

	localparam int unsigned OUT_WIDTH  = 16;
	localparam int unsigned CHAR_WIDTH = 8;

	localparam logic [CHAR_WIDTH-1:0] CH_END   = 8'd0;
	localparam logic [CHAR_WIDTH-1:0] CH_PLUS  = 8'd43;
	localparam logic [CHAR_WIDTH-1:0] CH_COMMA = 8'd44;
	localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'd45;
	localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'd48;

	typedef enum logic [1:0] {
		PH_FIRST  = 2'd0,
		PH_SECOND = 2'd1,
		PH_SKIP   = 2'd2
	} phase_t;

	typedef struct packed {
		logic signed [OUT_WIDTH-1:0] first_value;
		logic signed [OUT_WIDTH-1:0] second_value;
	} result_t;

	typedef struct packed {
		logic    emit;
		result_t result;
	} emit_t;

endpackage

>>> sv/tsdp_in_reg.sv
`timescale 1ns / 1ps
// input register holding one character item ahead of the parse logic
module tsdp_in_reg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              char_valid,
	input  logic                              char_stall,
	input  logic [tsdp_pkg::CHAR_WIDTH-1:0]   char_code,
	input  logic                              advance,
	output logic                              valid_s1,
	output logic [tsdp_pkg::CHAR_WIDTH-1:0]   char_s1
);

	logic load;

	assign load = char_valid && !char_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_s1 <= char_code;
		end
	end

endmodule

>>> sv/tsdp_core.sv
`timescale 1ns / 1ps
// field state and per-character fold of the parser
module tsdp_core #(
	parameter int unsigned VALUE_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  logic [tsdp_pkg::CHAR_WIDTH-1:0]   char_s1,
	output tsdp_pkg::emit_t                   emit
);

	tsdp_pkg::phase_t        phase_q, phase_d;
	logic                    start_q, start_d;
	logic                    neg_q, neg_d;
	logic [VALUE_WIDTH-1:0]  acc_q, acc_d;
	logic [VALUE_WIDTH-1:0]  held_q, held_d;

	logic [VALUE_WIDTH-1:0]  signed_val;
	logic [VALUE_WIDTH-1:0]  folded;
	logic                    is_end;

	assign is_end     = (char_s1 == tsdp_pkg::CH_END);
	assign signed_val = neg_q ? (VALUE_WIDTH'(0) - acc_q) : acc_q;
	// acc*10 as two shifts; byte minus '0' may go negative and wraps
	assign folded     = (acc_q << 3) + (acc_q << 1)
		+ VALUE_WIDTH'(char_s1) - VALUE_WIDTH'(tsdp_pkg::CH_ZERO);

	// next state
	always_comb begin
		phase_d = phase_q;
		start_d = start_q;
		neg_d   = neg_q;
		acc_d   = acc_q;
		held_d  = held_q;
		if (is_end) begin
			phase_d = tsdp_pkg::PH_FIRST;
			start_d = 1'b1;
			neg_d   = 1'b0;
			acc_d   = '0;
			held_d  = '0;
		end else begin
			case (phase_q)
				tsdp_pkg::PH_FIRST, tsdp_pkg::PH_SECOND: begin
					if (char_s1 == tsdp_pkg::CH_COMMA) begin
						if (phase_q == tsdp_pkg::PH_FIRST) begin
							held_d  = signed_val;
							phase_d = tsdp_pkg::PH_SECOND;
							start_d = 1'b1;
							neg_d   = 1'b0;
							acc_d   = '0;
						end else begin
							phase_d = tsdp_pkg::PH_SKIP;
						end
					end else if (start_q && (char_s1 == tsdp_pkg::CH_MINUS
						|| char_s1 == tsdp_pkg::CH_PLUS)) begin
						neg_d   = (char_s1 == tsdp_pkg::CH_MINUS);
						start_d = 1'b0;
					end else begin
						start_d = 1'b0;
						acc_d   = folded;
					end
				end
				default: begin
					// after a second comma everything up to the end byte is dropped
				end
			endcase
		end
	end

	// outputs
	always_comb begin
		emit.emit = step && is_end;
		if (phase_q == tsdp_pkg::PH_FIRST) begin
			emit.result.first_value  = signed_val[tsdp_pkg::OUT_WIDTH-1:0];
			emit.result.second_value = '0;
		end else begin
			emit.result.first_value  = held_q[tsdp_pkg::OUT_WIDTH-1:0];
			emit.result.second_value = signed_val[tsdp_pkg::OUT_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tsdp_pkg::PH_FIRST;
			start_q <= 1'b1;
			neg_q   <= 1'b0;
			acc_q   <= '0;
			held_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			start_q <= start_d;
			neg_q   <= neg_d;
			acc_q   <= acc_d;
			held_q  <= held_d;
		end
	end

endmodule

>>> sv/tsdp_out_reg.sv
`timescale 1ns / 1ps
// result register holding one parsed pair until it is taken
module tsdp_out_reg (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  tsdp_pkg::emit_t                         emit,
	input  logic                                    result_stall,
	output logic                                    can_load,
	output logic                                    result_valid,
	output logic signed [tsdp_pkg::OUT_WIDTH-1:0]   first_value,
	output logic signed [tsdp_pkg::OUT_WIDTH-1:0]   second_value
);

	tsdp_pkg::result_t result_q;

	assign can_load     = !result_valid || !result_stall;
	assign first_value  = result_q.first_value;
	assign second_value = result_q.second_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (emit.emit) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.emit) begin
			result_q <= emit.result;
		end
	end

endmodule

>>> sv/two_field_signed_decimal_parser.sv
`timescale 1ns / 1ps
// Parses a message of characters, one item per cycle, into two comma-separated
// signed decimal values. A field may open with '-' or '+'; every other byte
// before a comma or the zero byte is folded in as value*10 + (byte - '0') with
// no digit check, wrapping at VALUE_WIDTH bits. Bytes after a second comma are
// ignored. The zero byte produces one result item carrying both values (the
// second is zero when no comma came) and restarts the parser. A character
// passes an input register and is then folded into the field state, so
// the block takes one item every cycle while not stalled; a zero byte
// raises result_valid via the result register once folded. Only a zero byte
// that meets a full, stalled result register holds up the input side.
module two_field_signed_decimal_parser #(
	parameter int unsigned VALUE_WIDTH = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    char_valid,
	output logic                                    char_stall,
	input  logic [tsdp_pkg::CHAR_WIDTH-1:0]         char_code,
	output logic                                    result_valid,
	input  logic                                    result_stall,
	output logic signed [tsdp_pkg::OUT_WIDTH-1:0]   first_value,
	output logic signed [tsdp_pkg::OUT_WIDTH-1:0]   second_value
);

	logic                            valid_s1;
	logic [tsdp_pkg::CHAR_WIDTH-1:0] char_s1;
	logic                            advance;
	logic                            can_load;
	tsdp_pkg::emit_t                 emit;

	// only the end byte needs room in the result register
	assign advance    = valid_s1 && ((char_s1 != tsdp_pkg::CH_END) || can_load);
	assign char_stall = valid_s1 && !advance;

	tsdp_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_code  (char_code),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.char_s1    (char_s1)
	);

	tsdp_core #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.char_s1 (char_s1),
		.emit    (emit)
	);

	tsdp_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.emit         (emit),
		.result_stall (result_stall),
		.can_load     (can_load),
		.result_valid (result_valid),
		.first_value  (first_value),
		.second_value (second_value)
	);

`ifndef SYNTHESIS
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	a_plain_char_flows: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && char_s1 != tsdp_pkg::CH_END) |-> !char_stall)
		else $error("non-terminating item held in input register");

	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		emit.emit |=> result_valid)
		else $error("emitted result not presented");

	a_result_from_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(valid_s1 && char_s1 == tsdp_pkg::CH_END))
		else $error("result appeared without an end byte");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |-> !emit.emit)
		else $error("pending result overwritten");
`endif

endmodule
